>>> design/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the 1-Wire bus master
// Command classes, one-hot bus phases, slot timings and the request record
// that travels from the front end to the bus engine.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // Raw opcodes on the input channel.
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_RESET  = 3'd1;
  localparam logic [2:0] OP_WBYTE  = 3'd2;
  localparam logic [2:0] OP_RBYTE  = 3'd3;
  localparam logic [2:0] OP_WBIT   = 3'd4;
  localparam logic [2:0] OP_RBIT   = 3'd5;

  // Default depth of the request queue between front end and engine.
  localparam int QUEUE_DEPTH = 2;

  // Register map.
  localparam logic REG_TICKS_PER_US = 1'b0;

  // Reset status codes.
  localparam logic [1:0] ST_PRESENT  = 2'd0;
  localparam logic [1:0] ST_NO_PRES  = 2'd1;
  localparam logic [1:0] ST_STUCK    = 2'd2;

  // Phase lengths in microseconds.
  localparam logic [9:0] T_RST_LOW  = 10'd550;
  localparam logic [9:0] T_RST_W1   = 10'd70;
  localparam logic [9:0] T_RST_W2   = 10'd300;
  localparam logic [9:0] T_REC      = 10'd2;
  localparam logic [9:0] T_SHORT    = 10'd6;
  localparam logic [9:0] T_LONG     = 10'd64;
  localparam logic [9:0] T_R_LOW    = 10'd5;
  localparam logic [9:0] T_R_WAIT   = 10'd6;
  localparam logic [9:0] T_R_REST   = 10'd60;
  localparam logic [9:0] T_DEFAULT  = 10'd1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_WBYTE,
    CMD_RBYTE,
    CMD_WBIT,
    CMD_RBIT,
    CMD_UNUSED
  } cmd_t;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_RST_LOW = 11'b000_0000_0010,
    PH_RST_W1  = 11'b000_0000_0100,
    PH_RST_W2  = 11'b000_0000_1000,
    PH_W_REC   = 11'b000_0001_0000,
    PH_W_LOW   = 11'b000_0010_0000,
    PH_W_REST  = 11'b000_0100_0000,
    PH_R_REC   = 11'b000_1000_0000,
    PH_R_LOW   = 11'b001_0000_0000,
    PH_R_WAIT  = 11'b010_0000_0000,
    PH_R_REST  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       level;
  } req_t;

  function automatic logic [9:0] phase_length(phase_t ph, logic bit_val);
    logic [9:0] len;
    len = T_DEFAULT;
    unique case (ph)
      PH_RST_LOW: len = T_RST_LOW;
      PH_RST_W1:  len = T_RST_W1;
      PH_RST_W2:  len = T_RST_W2;
      PH_W_REC:   len = T_REC;
      PH_W_LOW:   len = bit_val ? T_SHORT : T_LONG;
      PH_W_REST:  len = bit_val ? T_LONG : T_SHORT;
      PH_R_REC:   len = T_REC;
      PH_R_LOW:   len = T_R_LOW;
      PH_R_WAIT:  len = T_R_WAIT;
      PH_R_REST:  len = T_R_REST;
      default:    len = T_DEFAULT;
    endcase
    return len;
  endfunction

endpackage

>>> design/owbm_front.sv
// ----------------------------------------------------------------------------
// owbm_front: request intake and queue
// Classifies the opcode of each accepted request and holds it in a small
// queue until the bus engine takes it.
// ----------------------------------------------------------------------------
module owbm_front #(
  parameter int QUEUE_DEPTH = owbm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_op,
  input  logic [7:0]          in_data,
  input  logic                in_line_level,
  output owbm_pkg::req_t      q_req,
  output logic                q_valid,
  input  logic                q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  owbm_pkg::req_t  mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  owbm_pkg::cmd_t  cmd;
  logic            push;
  logic            pop;

  always_comb begin
    unique case (in_op)
      owbm_pkg::OP_NONE:  cmd = owbm_pkg::CMD_NONE;
      owbm_pkg::OP_RESET: cmd = owbm_pkg::CMD_RESET;
      owbm_pkg::OP_WBYTE: cmd = owbm_pkg::CMD_WBYTE;
      owbm_pkg::OP_RBYTE: cmd = owbm_pkg::CMD_RBYTE;
      owbm_pkg::OP_WBIT:  cmd = owbm_pkg::CMD_WBIT;
      owbm_pkg::OP_RBIT:  cmd = owbm_pkg::CMD_RBIT;
      default:            cmd = owbm_pkg::CMD_UNUSED;
    endcase
  end

  assign in_stall = (count_r == FULL);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop;
  assign q_valid  = (count_r != '0);
  assign q_req    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{cmd: cmd, data: in_data, level: in_line_level};
    end
  end

endmodule

>>> design/owbm_back.sv
// ----------------------------------------------------------------------------
// owbm_back: bus engine and result register
// Advances the prescaler, the microsecond timer and the slot phases by one
// tick per request taken from the queue, and registers the tick's result.
// ----------------------------------------------------------------------------
module owbm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          ticks_per_us,
  input  owbm_pkg::req_t      q_req,
  input  logic                q_valid,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_drive_low,
  output logic                out_busy_res,
  output logic                out_done_res,
  output logic [7:0]          out_read_data,
  output logic [1:0]          out_status,
  output logic                out_rejected
);

  owbm_pkg::phase_t phase_r, phase_nxt;
  logic [9:0]  us_r, us_nxt;
  logic [7:0]  presc_r, presc_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        byte_mode_r, byte_mode_nxt;
  logic [1:0]  status_r, status_nxt;

  logic        out_valid_r;
  logic        drive_r, busy_r, done_r, rej_r;
  logic [7:0]  rd_r;

  logic        fire;
  logic        done, rej;
  logic [7:0]  rd;
  logic [7:0]  lim;
  logic [9:0]  len;
  logic        lvl;

  assign fire      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = fire;
  assign lvl       = q_req.level;
  // A zero prescale setting behaves as one tick per microsecond.
  assign lim       = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
  assign len       = owbm_pkg::phase_length(phase_r, shift_r[0]);

  always_comb begin
    phase_nxt     = phase_r;
    us_nxt        = us_r;
    presc_nxt     = presc_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    byte_mode_nxt = byte_mode_r;
    status_nxt    = status_r;
    done          = 1'b0;
    rej           = 1'b0;
    rd            = 8'd0;
    if (phase_r == owbm_pkg::PH_IDLE) begin
      unique case (q_req.cmd)
        owbm_pkg::CMD_RESET: begin
          phase_nxt = owbm_pkg::PH_RST_LOW;
        end
        owbm_pkg::CMD_WBYTE: begin
          byte_mode_nxt = 1'b1;
          shift_nxt     = q_req.data;
          phase_nxt     = owbm_pkg::PH_W_REC;
        end
        owbm_pkg::CMD_RBYTE: begin
          byte_mode_nxt = 1'b1;
          shift_nxt     = 8'd0;
          phase_nxt     = owbm_pkg::PH_R_REC;
        end
        owbm_pkg::CMD_WBIT: begin
          byte_mode_nxt = 1'b0;
          shift_nxt     = {7'd0, q_req.data[0]};
          phase_nxt     = owbm_pkg::PH_W_REC;
        end
        owbm_pkg::CMD_RBIT: begin
          byte_mode_nxt = 1'b0;
          shift_nxt     = 8'd0;
          phase_nxt     = owbm_pkg::PH_R_REC;
        end
        default: begin
        end
      endcase
      if (phase_nxt != owbm_pkg::PH_IDLE) begin
        us_nxt      = 10'd0;
        presc_nxt   = 8'd0;
        bit_idx_nxt = 3'd0;
      end
    end else begin
      rej = (q_req.cmd != owbm_pkg::CMD_NONE);
      if ({1'b0, presc_r} + 9'd1 >= {1'b0, lim}) begin
        presc_nxt = 8'd0;
        if ({1'b0, us_r} + 11'd1 >= {1'b0, len}) begin
          us_nxt = 10'd0;
          unique case (phase_r)
            owbm_pkg::PH_RST_LOW: phase_nxt = owbm_pkg::PH_RST_W1;
            owbm_pkg::PH_RST_W1: begin
              if (lvl) begin
                status_nxt = owbm_pkg::ST_NO_PRES;
                done       = 1'b1;
              end else begin
                phase_nxt = owbm_pkg::PH_RST_W2;
              end
            end
            owbm_pkg::PH_RST_W2: begin
              status_nxt = lvl ? owbm_pkg::ST_PRESENT : owbm_pkg::ST_STUCK;
              done       = 1'b1;
            end
            owbm_pkg::PH_W_REC: phase_nxt = owbm_pkg::PH_W_LOW;
            owbm_pkg::PH_W_LOW: phase_nxt = owbm_pkg::PH_W_REST;
            owbm_pkg::PH_W_REST: begin
              if (byte_mode_r && bit_idx_r != 3'd7) begin
                bit_idx_nxt = bit_idx_r + 3'd1;
                shift_nxt   = {1'b0, shift_r[7:1]};
                phase_nxt   = owbm_pkg::PH_W_REC;
              end else begin
                done = 1'b1;
              end
            end
            owbm_pkg::PH_R_REC: phase_nxt = owbm_pkg::PH_R_LOW;
            owbm_pkg::PH_R_LOW: phase_nxt = owbm_pkg::PH_R_WAIT;
            owbm_pkg::PH_R_WAIT: begin
              // Byte reads shift each sampled bit in from the top.
              shift_nxt = byte_mode_r ? {lvl, shift_r[7:1]} : {7'd0, lvl};
              phase_nxt = owbm_pkg::PH_R_REST;
            end
            owbm_pkg::PH_R_REST: begin
              if (byte_mode_r && bit_idx_r != 3'd7) begin
                bit_idx_nxt = bit_idx_r + 3'd1;
                phase_nxt   = owbm_pkg::PH_R_REC;
              end else begin
                rd   = shift_r;
                done = 1'b1;
              end
            end
            default: phase_nxt = owbm_pkg::PH_IDLE;
          endcase
          if (done) begin
            phase_nxt   = owbm_pkg::PH_IDLE;
            bit_idx_nxt = 3'd0;
          end
        end else begin
          us_nxt = us_r + 10'd1;
        end
      end else begin
        presc_nxt = presc_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owbm_pkg::PH_IDLE;
      us_r        <= 10'd0;
      presc_r     <= 8'd0;
      bit_idx_r   <= 3'd0;
      shift_r     <= 8'd0;
      byte_mode_r <= 1'b0;
      status_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        us_r        <= us_nxt;
        presc_r     <= presc_nxt;
        bit_idx_r   <= bit_idx_nxt;
        shift_r     <= shift_nxt;
        byte_mode_r <= byte_mode_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r <= (phase_nxt == owbm_pkg::PH_RST_LOW) || (phase_nxt == owbm_pkg::PH_W_LOW)
              || (phase_nxt == owbm_pkg::PH_R_LOW);
      busy_r  <= (phase_nxt != owbm_pkg::PH_IDLE);
      done_r  <= done;
      rd_r    <= rd;
      rej_r   <= rej;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_low = drive_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_read_data = rd_r;
  assign out_status    = status_r;
  assign out_rejected  = rej_r;

endmodule

>>> design/one_wire_bus_master_core.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_core: standard-speed 1-Wire bus master
// Each request on the input channel is one tick of the timing base: an
// opcode, a data byte and the sampled bus level. Each request yields exactly
// one result: the bus drive, busy, done, read data, reset status and a
// rejected flag for a command that arrived while an operation was running.
// The ticks_per_us register (byte address 0) sets the prescaler. The user is to
// write it over the APB-style port while the block is idle; the block does not enforce this.
// A request is accepted when in_valid is high and in_stall is low; it enters
// a short queue, the bus engine takes it from there once the result register
// is free or being read, and the result of its tick is registered and offered.
// Throughput is one request per cycle while out_stall is low, one engine step each.
// If out_stall is held, the result register holds its value, the engine
// pauses and the queue fills; in_stall rises once the queue is full.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid, puts
// the engine in idle with status 0 and sets ticks_per_us to 1.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core #(
  parameter int QUEUE_DEPTH = owbm_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [2:0]   in_op,
  input  logic [7:0]   in_data,
  input  logic         in_line_level,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_drive_low,
  output logic         out_busy_res,
  output logic         out_done_res,
  output logic [7:0]   out_read_data,
  output logic [1:0]   out_status,
  output logic         out_rejected,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [7:0]       ticks_r;
  owbm_pkg::req_t   q_req;
  logic             q_valid;
  logic             q_pop;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == owbm_pkg::REG_TICKS_PER_US);
  assign prdata  = reg_hit ? {24'd0, ticks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= 8'd1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      ticks_r <= pwdata[7:0];
    end
  end

  owbm_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data      (in_data),
    .in_line_level(in_line_level),
    .q_req        (q_req),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  owbm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .ticks_per_us (ticks_r),
    .q_req        (q_req),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drive_low(out_drive_low),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_read_data(out_read_data),
    .out_status   (out_status),
    .out_rejected (out_rejected)
  );

endmodule

>>> tb/one_wire_bus_master_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_core_tb: self-checking bench for the 1-Wire bus master
// Feeds bus ticks through the request channel and checks every result against
// a cycle-exact model of the slot sequencer. A scripted part covers a reset
// without presence, a rejected command, a byte read, the slowest prescaler
// and a prescaler change in the middle of a slot. A random part follows,
// with stalls on both sides.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core_tb;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic [1:0] status;
    logic       rejected;
  } bus_result_t;

  typedef struct packed {
    logic        set_rate;
    logic [7:0]  rate;
    logic [2:0]  op;
    logic [7:0]  data;
    logic [1:0]  line;
    logic [15:0] reps;
    logic        check_last;
    bus_result_t want;
  } script_row_t;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [1:0] LINE_LO = 2'd0;
  localparam logic [1:0] LINE_HI = 2'd1;
  localparam logic [1:0] LINE_RAND = 2'd2;
  localparam logic [2:0] ADDR_TICKS = {owbm_pkg::REG_TICKS_PER_US, 2'b00};
  localparam bus_result_t NO_ACTIVITY = '0;
  localparam int N_ROWS = 13;

  // Timing at one tick per microsecond: low for 550 ticks, then the presence
  // sample 70 ticks later; a byte read runs 8 x 73 ticks.
  localparam script_row_t SCRIPT [N_ROWS] = '{
    '{1'b1, 8'd1, owbm_pkg::OP_NONE, 8'h00, LINE_HI, 16'd3, 1'b1, NO_ACTIVITY},
    '{1'b0, 8'd0, OP_SPARE_B, 8'hFF, LINE_LO, 16'd1, 1'b1, NO_ACTIVITY},
    '{1'b0, 8'd0, OP_SPARE_A, 8'h00, LINE_HI, 16'd1, 1'b1, NO_ACTIVITY},
    '{1'b0, 8'd0, owbm_pkg::OP_RESET, 8'h00, LINE_LO, 16'd1, 1'b1,
      '{1'b1, 1'b1, 1'b0, 8'h00, owbm_pkg::ST_PRESENT, 1'b0}},
    '{1'b0, 8'd0, owbm_pkg::OP_NONE, 8'h00, LINE_LO, 16'd300, 1'b0, NO_ACTIVITY},
    '{1'b0, 8'd0, owbm_pkg::OP_WBYTE, 8'hFF, LINE_LO, 16'd1, 1'b1,
      '{1'b1, 1'b1, 1'b0, 8'h00, owbm_pkg::ST_PRESENT, 1'b1}},
    '{1'b0, 8'd0, owbm_pkg::OP_NONE, 8'h00, LINE_LO, 16'd318, 1'b0, NO_ACTIVITY},
    '{1'b0, 8'd0, owbm_pkg::OP_NONE, 8'h00, LINE_HI, 16'd1, 1'b1,
      '{1'b0, 1'b0, 1'b1, 8'h00, owbm_pkg::ST_NO_PRES, 1'b0}},
    '{1'b0, 8'd0, owbm_pkg::OP_RBYTE, 8'h00, LINE_RAND, 16'd1, 1'b0, NO_ACTIVITY},
    '{1'b0, 8'd0, owbm_pkg::OP_NONE, 8'h00, LINE_RAND, 16'd584, 1'b0, NO_ACTIVITY},
    '{1'b1, 8'd255, owbm_pkg::OP_WBIT, 8'hFF, LINE_RAND, 16'd1, 1'b0, NO_ACTIVITY},
    '{1'b0, 8'd0, owbm_pkg::OP_NONE, 8'h00, LINE_RAND, 16'd40, 1'b0, NO_ACTIVITY},
    // The prescaler count sits above the new limit here, mid-slot.
    '{1'b1, 8'd1, owbm_pkg::OP_NONE, 8'h00, LINE_RAND, 16'd75, 1'b0, NO_ACTIVITY}
  };

  localparam int N_RAND_PHASES = 3;
  localparam logic [7:0] RAND_RATES [N_RAND_PHASES] = '{8'd0, 8'd2, 8'd1};
  localparam int RAND_ITEMS [N_RAND_PHASES] = '{50, 40, 50};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = owbm_pkg::OP_NONE;
  logic [7:0]  in_data = 8'h00;
  logic        in_line_level = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_drive_low;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_read_data;
  logic [1:0]  out_status;
  logic        out_rejected;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  one_wire_bus_master_core dut (.*);

  // Model of the bus engine.
  logic [7:0]       tick_rate = 8'd1;
  owbm_pkg::phase_t ph = owbm_pkg::PH_IDLE;
  logic [9:0]       us_cnt = '0;
  logic [7:0]       pre_cnt = '0;
  logic [2:0]       bit_idx = '0;
  logic [7:0]       shreg = '0;
  logic             byte_mode = 1'b0;
  logic [1:0]       last_st = owbm_pkg::ST_PRESENT;

  bus_result_t due_results[$];
  int          mismatches = 0;
  logic        send_quiet = 1'b0;
  logic        stall_quiet = 1'b0;
  logic        hold_req = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int slot_len();
    case (ph)
      owbm_pkg::PH_RST_LOW: return 550;
      owbm_pkg::PH_RST_W1:  return 70;
      owbm_pkg::PH_RST_W2:  return 300;
      owbm_pkg::PH_W_REC:   return 2;
      owbm_pkg::PH_W_LOW:   return shreg[0] ? 6 : 64;
      owbm_pkg::PH_W_REST:  return shreg[0] ? 64 : 6;
      owbm_pkg::PH_R_REC:   return 2;
      owbm_pkg::PH_R_LOW:   return 5;
      owbm_pkg::PH_R_WAIT:  return 6;
      owbm_pkg::PH_R_REST:  return 60;
      default:              return 1;
    endcase
  endfunction

  function automatic bus_result_t advance_bus(logic [2:0] op, logic [7:0] data, logic lvl);
    bus_result_t r;
    int lim;
    r = '0;
    lim = (tick_rate == 8'd0) ? 1 : int'(tick_rate);
    if (ph == owbm_pkg::PH_IDLE) begin
      if (op inside {owbm_pkg::OP_RESET, owbm_pkg::OP_WBYTE, owbm_pkg::OP_RBYTE,
                     owbm_pkg::OP_WBIT, owbm_pkg::OP_RBIT}) begin
        us_cnt = '0;
        pre_cnt = '0;
        bit_idx = '0;
      end
      case (op)
        owbm_pkg::OP_RESET: ph = owbm_pkg::PH_RST_LOW;
        owbm_pkg::OP_WBYTE: begin
          byte_mode = 1'b1;
          shreg = data;
          ph = owbm_pkg::PH_W_REC;
        end
        owbm_pkg::OP_RBYTE: begin
          byte_mode = 1'b1;
          shreg = '0;
          ph = owbm_pkg::PH_R_REC;
        end
        owbm_pkg::OP_WBIT: begin
          byte_mode = 1'b0;
          shreg = {7'd0, data[0]};
          ph = owbm_pkg::PH_W_REC;
        end
        owbm_pkg::OP_RBIT: begin
          byte_mode = 1'b0;
          shreg = '0;
          ph = owbm_pkg::PH_R_REC;
        end
        default: ;
      endcase
    end else begin
      r.rejected = (op != owbm_pkg::OP_NONE);
      if (int'(pre_cnt) + 1 >= lim) begin
        pre_cnt = '0;
        if (int'(us_cnt) + 1 >= slot_len()) begin
          us_cnt = '0;
          case (ph)
            owbm_pkg::PH_RST_LOW: ph = owbm_pkg::PH_RST_W1;
            owbm_pkg::PH_RST_W1: begin
              if (lvl) begin
                last_st = owbm_pkg::ST_NO_PRES;
                r.done = 1'b1;
              end else begin
                ph = owbm_pkg::PH_RST_W2;
              end
            end
            owbm_pkg::PH_RST_W2: begin
              last_st = lvl ? owbm_pkg::ST_PRESENT : owbm_pkg::ST_STUCK;
              r.done = 1'b1;
            end
            owbm_pkg::PH_W_REC: ph = owbm_pkg::PH_W_LOW;
            owbm_pkg::PH_W_LOW: ph = owbm_pkg::PH_W_REST;
            owbm_pkg::PH_W_REST: begin
              if (byte_mode && bit_idx != 3'd7) begin
                bit_idx = bit_idx + 3'd1;
                shreg = shreg >> 1;
                ph = owbm_pkg::PH_W_REC;
              end else begin
                r.done = 1'b1;
              end
            end
            owbm_pkg::PH_R_REC: ph = owbm_pkg::PH_R_LOW;
            owbm_pkg::PH_R_LOW: ph = owbm_pkg::PH_R_WAIT;
            owbm_pkg::PH_R_WAIT: begin
              shreg = byte_mode ? {lvl, shreg[7:1]} : {7'd0, lvl};
              ph = owbm_pkg::PH_R_REST;
            end
            owbm_pkg::PH_R_REST: begin
              if (byte_mode && bit_idx != 3'd7) begin
                bit_idx = bit_idx + 3'd1;
                ph = owbm_pkg::PH_R_REC;
              end else begin
                r.read_data = shreg;
                r.done = 1'b1;
              end
            end
            default: ph = owbm_pkg::PH_IDLE;
          endcase
          if (r.done) begin
            ph = owbm_pkg::PH_IDLE;
            bit_idx = '0;
          end
        end else begin
          us_cnt = us_cnt + 10'd1;
        end
      end else begin
        pre_cnt = pre_cnt + 8'd1;
      end
    end
    r.drive_low = (ph == owbm_pkg::PH_RST_LOW) || (ph == owbm_pkg::PH_W_LOW) ||
                  (ph == owbm_pkg::PH_R_LOW);
    r.busy = (ph != owbm_pkg::PH_IDLE);
    r.status = last_st;
    return r;
  endfunction

  // Mostly no pause, sometimes a short one, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic string show(bus_result_t r);
    return $sformatf("drv=%0b busy=%0b done=%0b rd=%02h st=%0d rej=%0b",
                     r.drive_low, r.busy, r.done, r.read_data, r.status, r.rejected);
  endfunction

  task automatic flag_error(string msg);
    if (mismatches < 10) $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Called at a rising edge; returns at the edge that takes the request.
  task automatic send_tick(logic [2:0] op, logic [7:0] data, logic lvl,
                           logic pinned, bus_result_t pinned_res);
    bus_result_t r;
    int gap;
    gap = send_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data <= data;
    in_line_level <= lvl;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    r = advance_bus(op, data, lvl);
    due_results.push_back(pinned ? pinned_res : r);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic program_rate(logic [7:0] value);
    wait_for_results();
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TICKS;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    tick_rate = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata[7:0] !== value)
      flag_error($sformatf("ticks_per_us reads %02h, expected %02h", prdata[7:0], value));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 120;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = stall_quiet ? 0 : idle_len();
      end
    end
  end

  initial begin
    bus_result_t got;
    bus_result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_drive_low, out_busy_res, out_done_res, out_read_data,
                out_status, out_rejected};
        if (due_results.size() == 0) begin
          flag_error($sformatf("result with no request outstanding: %s", show(got)));
        end else begin
          want = due_results.pop_front();
          if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
              got.done !== want.done || got.read_data !== want.read_data ||
              got.status !== want.status || got.rejected !== want.rejected)
            flag_error($sformatf("expected %s, got %s", show(want), show(got)));
        end
      end
    end
  end

  initial begin
    script_row_t row;
    logic        lvl;
    logic [2:0]  op;
    int          roll;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      row = SCRIPT[i];
      if (row.set_rate) program_rate(row.rate);
      for (int k = 0; k < int'(row.reps); k++) begin
        lvl = (row.line == LINE_RAND) ? 1'($urandom_range(0, 1)) : row.line[0];
        send_tick(row.op, row.data, lvl, row.check_last && (k == int'(row.reps) - 1),
                  row.want);
      end
    end

    for (int p = 0; p < N_RAND_PHASES; p++) begin
      program_rate(RAND_RATES[p]);
      send_quiet = (p == 2);
      stall_quiet = (p == 2);
      for (int n = 0; n < RAND_ITEMS[p]; n++) begin
        if (p == 0 && n == 10) hold_req = 1'b1;
        if (p == 1 && n == 20) wait_for_results();
        // Commands mostly start from idle; a few land mid-operation as noise.
        if (ph == owbm_pkg::PH_IDLE) begin
          roll = $urandom_range(0, 99);
          if (roll < 25) op = owbm_pkg::OP_NONE;
          else if (roll < 45) op = owbm_pkg::OP_WBIT;
          else if (roll < 65) op = owbm_pkg::OP_RBIT;
          else if (roll < 76) op = owbm_pkg::OP_WBYTE;
          else if (roll < 87) op = owbm_pkg::OP_RBYTE;
          else if (roll < 95) op = owbm_pkg::OP_RESET;
          else op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_B));
        end else begin
          op = ($urandom_range(0, 24) == 0) ?
               3'($urandom_range(owbm_pkg::OP_RESET, OP_SPARE_B)) : owbm_pkg::OP_NONE;
        end
        send_tick(op, 8'($urandom), 1'($urandom), 1'b0, NO_ACTIVITY);
      end
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
